FILE: rtl/core/kvt_pkg.sv
`timescale 1ns / 1ps

package kvt_pkg;

  localparam int DEPTH_DEF       = 16;
  localparam int KEY_WIDTH_DEF   = 16;
  localparam int VALUE_WIDTH_DEF = 32;

  localparam int FUNC_W   = 2;
  localparam int STATUS_W = 3;

  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_CHANGE = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;

  // controller -> datapath
  typedef struct packed {
    logic load;     // capture request, restart scan
    logic scan_rd;  // read the entry at the scan index
    logic finish;   // commit and load the result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_last;  // scan index sits on the last entry
    logic out_free;   // result register can take a new result
  } sts_t;

endpackage

FILE: rtl/core/kvt_ctrl.sv
`timescale 1ns / 1ps

module kvt_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  kvt_pkg::sts_t sts,
  output kvt_pkg::cmd_t cmd,
  output logic          in_stall
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_DRAIN  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next   = state;
    cmd.load     = 1'b0;
    cmd.scan_rd  = 1'b0;
    cmd.finish   = 1'b0;
    in_stall     = 1'b1;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.scan_last) begin
          state_next = S_DRAIN;
        end
      end
      // last read compares here
      S_DRAIN: begin
        state_next = S_FINISH;
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/kvt_dpath.sv
`timescale 1ns / 1ps

module kvt_dpath #(
  parameter int DEPTH       = kvt_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH   = kvt_pkg::KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = kvt_pkg::VALUE_WIDTH_DEF,
  localparam int IW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  kvt_pkg::cmd_t                cmd,
  output kvt_pkg::sts_t                sts,
  input  logic [kvt_pkg::FUNC_W-1:0]   func,
  input  logic [KEY_WIDTH-1:0]         key,
  input  logic [VALUE_WIDTH-1:0]       value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [kvt_pkg::STATUS_W-1:0] status,
  output logic [VALUE_WIDTH-1:0]       read_value,
  output logic [CW-1:0]                entry_count
);

  logic [KEY_WIDTH-1:0]   mem_key  [DEPTH];
  logic [VALUE_WIDTH-1:0] mem_data [DEPTH];
  logic [DEPTH-1:0]       entry_valid;
  logic [CW-1:0]          valid_count;

  // captured request
  logic [kvt_pkg::FUNC_W-1:0] func_q;
  logic [KEY_WIDTH-1:0]       key_q;
  logic [VALUE_WIDTH-1:0]     value_q;

  // scan read stage
  logic [IW-1:0]          scan_idx;
  logic                   rd_pend;
  logic [KEY_WIDTH-1:0]   key_rd;
  logic [VALUE_WIDTH-1:0] data_rd;
  logic                   vld_rd;
  logic [IW-1:0]          idx_rd;

  // scan results
  logic                   found;
  logic [IW-1:0]          match_idx;
  logic [VALUE_WIDTH-1:0] match_data;
  logic                   free_found;
  logic [IW-1:0]          free_idx;

  // commit decision
  logic                         wr_key;
  logic                         wr_data;
  logic [IW-1:0]                wr_idx;
  logic                         set_valid;
  logic                         clr_valid;
  logic [kvt_pkg::STATUS_W-1:0] res_status;
  logic [VALUE_WIDTH-1:0]       res_value;
  logic [CW-1:0]                count_next;
  logic                         fire;

  assign sts.scan_last = (scan_idx == IW'(DEPTH - 1));
  assign sts.out_free  = !out_valid || !out_stall;
  assign fire          = cmd.finish;

  always_comb begin
    wr_key     = 1'b0;
    wr_data    = 1'b0;
    wr_idx     = match_idx;
    set_valid  = 1'b0;
    clr_valid  = 1'b0;
    res_status = kvt_pkg::ST_OK;
    res_value  = '0;
    count_next = valid_count;
    if (func_q == kvt_pkg::FUNC_ADD) begin
      if (found) begin
        res_status = kvt_pkg::ST_DUP;
      end else if (!free_found) begin
        res_status = kvt_pkg::ST_FULL;
      end else begin
        wr_key     = 1'b1;
        wr_data    = 1'b1;
        wr_idx     = free_idx;
        set_valid  = 1'b1;
        count_next = valid_count + CW'(1);
      end
    end else if (valid_count == '0) begin
      res_status = kvt_pkg::ST_EMPTY;
    end else if (!found) begin
      res_status = kvt_pkg::ST_NOTFOUND;
    end else begin
      case (func_q)
        kvt_pkg::FUNC_DELETE: begin
          clr_valid  = 1'b1;
          count_next = valid_count - CW'(1);
        end
        kvt_pkg::FUNC_LOOKUP: begin
          res_value = match_data;
        end
        kvt_pkg::FUNC_CHANGE: begin
          wr_data = 1'b1;
        end
        default: begin
          res_status = kvt_pkg::ST_OK;
        end
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (fire && wr_key) begin
      mem_key[wr_idx] <= key_q;
    end
    if (fire && wr_data) begin
      mem_data[wr_idx] <= value_q;
    end
    if (cmd.scan_rd) begin
      key_rd  <= mem_key[scan_idx];
      data_rd <= mem_data[scan_idx];
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q  <= func;
      key_q   <= key;
      value_q <= value;
    end
    if (cmd.scan_rd) begin
      vld_rd <= entry_valid[scan_idx];
      idx_rd <= scan_idx;
    end
    if (rd_pend && vld_rd && key_rd == key_q && !found) begin
      match_idx  <= idx_rd;
      match_data <= data_rd;
    end
    if (rd_pend && !vld_rd && !free_found) begin
      free_idx <= idx_rd;
    end
    if (fire) begin
      status      <= res_status;
      read_value  <= res_value;
      entry_count <= count_next;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_valid <= '0;
      valid_count <= '0;
      scan_idx    <= '0;
      rd_pend     <= 1'b0;
      found       <= 1'b0;
      free_found  <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      rd_pend <= cmd.scan_rd;
      if (cmd.load) begin
        scan_idx   <= '0;
        found      <= 1'b0;
        free_found <= 1'b0;
      end else begin
        if (cmd.scan_rd) begin
          scan_idx <= scan_idx + IW'(1);
        end
        if (rd_pend && vld_rd && key_rd == key_q) begin
          found <= 1'b1;
        end
        if (rd_pend && !vld_rd) begin
          free_found <= 1'b1;
        end
      end
      if (fire) begin
        valid_count <= count_next;
        if (set_valid) begin
          entry_valid[wr_idx] <= 1'b1;
        end
        if (clr_valid) begin
          entry_valid[wr_idx] <= 1'b0;
        end
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/core/key_value_table.sv
`timescale 1ns / 1ps

// Key/value table of DEPTH entries with unique keys. Each request (add,
// delete, lookup, change) scans every entry through a registered memory
// read, one entry per cycle. After the transfer in, the scan reads all
// DEPTH entries, the last read is compared in the drain state and the
// result is committed in the finish state. No new request is taken until
// that commit. A result waits in an output register; the next request is
// taken while it waits, and its commit, with the input stalled, is held
// until that register frees. There is no clearing pass after reset: entry
// valid bits are flops cleared by rst.

module key_value_table #(
  parameter int DEPTH       = kvt_pkg::DEPTH_DEF,
  parameter int KEY_WIDTH   = kvt_pkg::KEY_WIDTH_DEF,
  parameter int VALUE_WIDTH = kvt_pkg::VALUE_WIDTH_DEF,
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [kvt_pkg::FUNC_W-1:0]   func,
  input  logic [KEY_WIDTH-1:0]         key,
  input  logic [VALUE_WIDTH-1:0]       value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [kvt_pkg::STATUS_W-1:0] status,
  output logic [VALUE_WIDTH-1:0]       read_value,
  output logic [CW-1:0]                entry_count
);

  kvt_pkg::cmd_t cmd;
  kvt_pkg::sts_t sts;

  kvt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  kvt_dpath #(
    .DEPTH       (DEPTH),
    .KEY_WIDTH   (KEY_WIDTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .func        (func),
    .key         (key),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .read_value  (read_value),
    .entry_count (entry_count)
  );

endmodule

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import kvt_pkg::*;

  localparam int DEPTH       = DEPTH_DEF;
  localparam int KW          = KEY_WIDTH_DEF;
  localparam int VW          = VALUE_WIDTH_DEF;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int ITEM_TARGET = 1600;
  localparam int QUIET_ITEMS = 150;
  localparam int HOLD_CYCLES = 160;
  localparam int POOL_SIZE   = 24;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [VW-1:0]       read_value;
    logic [CNT_W-1:0]    entry_count;
  } kv_reply_t;

  // Table model: tracks slots, predicts the reply of each accepted request
  // and checks replies in order.
  class kv_scoreboard;
    logic [KW-1:0] slot_key [DEPTH];
    logic [VW-1:0] slot_data [DEPTH];
    bit            slot_used [DEPTH];
    int unsigned   used_count;
    kv_reply_t     expected_replies [$];
    int unsigned   error_count;
    int unsigned   checked_count;
    int unsigned   status_seen [5];

    function new();
      foreach (slot_used[i]) slot_used[i] = 1'b0;
      foreach (status_seen[i]) status_seen[i] = 0;
      used_count    = 0;
      error_count   = 0;
      checked_count = 0;
    endfunction

    function int find_slot(logic [KW-1:0] k);
      for (int i = 0; i < DEPTH; i++) begin
        if (slot_used[i] && slot_key[i] == k) return i;
      end
      return -1;
    endfunction

    function int find_free();
      for (int i = 0; i < DEPTH; i++) begin
        if (!slot_used[i]) return i;
      end
      return -1;
    endfunction

    function void note_request(logic [FUNC_W-1:0] f, logic [KW-1:0] k, logic [VW-1:0] v);
      kv_reply_t r;
      int slot;
      r.status     = ST_OK;
      r.read_value = '0;
      if (f == FUNC_ADD) begin
        if (find_slot(k) >= 0) begin
          r.status = ST_DUP;
        end else begin
          slot = find_free();
          if (slot < 0) begin
            r.status = ST_FULL;
          end else begin
            slot_key[slot]  = k;
            slot_data[slot] = v;
            slot_used[slot] = 1'b1;
            used_count++;
          end
        end
      end else if (used_count == 0) begin
        r.status = ST_EMPTY;
      end else begin
        slot = find_slot(k);
        if (slot < 0) begin
          r.status = ST_NOTFOUND;
        end else if (f == FUNC_DELETE) begin
          slot_used[slot] = 1'b0;
          used_count--;
        end else if (f == FUNC_LOOKUP) begin
          r.read_value = slot_data[slot];
        end else begin
          slot_data[slot] = v;
        end
      end
      r.entry_count = used_count[CNT_W-1:0];
      expected_replies.push_back(r);
    endfunction

    task report_mismatch(string what);
      error_count++;
      $display("[%0t] MISMATCH: %s", $time, what);
    endtask

    task check_reply(logic [STATUS_W-1:0] st, logic [VW-1:0] rv, logic [CNT_W-1:0] cnt);
      kv_reply_t e;
      if (expected_replies.size() == 0) begin
        report_mismatch("reply with no request pending");
      end else begin
        e = expected_replies.pop_front();
        checked_count++;
        if (e.status < 5) status_seen[e.status]++;
        if (st !== e.status)
          report_mismatch($sformatf("reply %0d status %0d, expected %0d",
                                    checked_count, st, e.status));
        if (rv !== e.read_value)
          report_mismatch($sformatf("reply %0d read_value %h, expected %h",
                                    checked_count, rv, e.read_value));
        if (cnt !== e.entry_count)
          report_mismatch($sformatf("reply %0d entry_count %0d, expected %0d",
                                    checked_count, cnt, e.entry_count));
      end
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [FUNC_W-1:0]   func = FUNC_ADD;
  logic [KW-1:0]       key = '0;
  logic [VW-1:0]       value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [VW-1:0]       read_value;
  logic [CNT_W-1:0]    entry_count;

  kv_scoreboard  sb;
  logic [KW-1:0] key_pool [POOL_SIZE];
  int unsigned   sent_count = 0;
  int unsigned   send_idle_pct = 0;
  int unsigned   recv_idle_pct = 0;
  bit            quiet = 1'b0;
  bit            long_hold_req = 1'b0;
  int unsigned   full_fills = 0;
  int unsigned   drains = 0;

  key_value_table DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .func        (func),
    .key         (key),
    .value       (value),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .read_value  (read_value),
    .entry_count (entry_count)
  );

  always #5 clk = ~clk;

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_reply(status, read_value, entry_count);
  end

  // Output side: random stall bursts, plus one long hold-off on request.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        out_stall     = 1'b0;
        long_hold_req = 1'b0;
      end else if (!quiet && $urandom_range(99) < recv_idle_pct) begin
        n = $urandom_range(1, 11);
        out_stall = 1'b1;
        repeat (n) @(negedge clk);
        out_stall = 1'b0;
      end else begin
        out_stall = 1'b0;
      end
    end
  end

  task automatic send_request(logic [FUNC_W-1:0] f, logic [KW-1:0] k, logic [VW-1:0] v);
    int gap;
    gap = 0;
    if (!quiet && $urandom_range(99) < send_idle_pct) gap = $urandom_range(1, 11);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    func     = f;
    key      = k;
    value    = v;
    do @(posedge clk); while (in_stall);
    sb.note_request(f, k, v);
    sent_count++;
  endtask

  // drop valid first so the last transfer is not taken again
  task automatic wait_all_replies();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.expected_replies.size() != 0) @(posedge clk);
  endtask

  function automatic logic [KW-1:0] present_key();
    int i;
    i = $urandom_range(DEPTH - 1);
    while (!sb.slot_used[i]) i = (i + 1) % DEPTH;
    return sb.slot_key[i];
  endfunction

  // a pool key not in the table, else an unchecked random key
  function automatic logic [KW-1:0] fresh_key();
    logic [KW-1:0] k;
    for (int t = 0; t < 8; t++) begin
      k = key_pool[$urandom_range(POOL_SIZE - 1)];
      if (sb.find_slot(k) < 0) return k;
    end
    return KW'($urandom);
  endfunction

  function automatic logic [KW-1:0] mixed_key();
    int r;
    r = $urandom_range(99);
    if (r < 65 && sb.used_count > 0) return present_key();
    if (r < 90) return key_pool[$urandom_range(POOL_SIZE - 1)];
    return KW'($urandom);
  endfunction

  function automatic int unsigned pick_pct();
    case ($urandom_range(3))
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 60;
    endcase
  endfunction

  task automatic run_fill();
    while (sb.used_count < DEPTH) send_request(FUNC_ADD, fresh_key(), $urandom);
    full_fills++;
    send_request(FUNC_ADD, fresh_key(), $urandom);
    if ($urandom_range(1)) send_request(FUNC_ADD, present_key(), $urandom);
    send_request(FUNC_LOOKUP, present_key(), $urandom);
  endtask

  task automatic run_drain();
    int r;
    while (sb.used_count > 0) begin
      r = $urandom_range(9);
      if (r < 6) send_request(FUNC_DELETE, present_key(), $urandom);
      else if (r < 8) send_request(FUNC_LOOKUP, present_key(), $urandom);
      else send_request(FUNC_CHANGE, present_key(), $urandom);
    end
    drains++;
    send_request(FUNC_W'($urandom_range(1, 3)), mixed_key(), $urandom);
  endtask

  task automatic run_mixed();
    int n;
    n = $urandom_range(20, 60);
    repeat (n) send_request(FUNC_W'($urandom_range(3)), mixed_key(), $urandom);
  endtask

  task automatic run_noise();
    int n;
    n = $urandom_range(5, 15);
    repeat (n) send_request(FUNC_W'($urandom_range(3)), KW'($urandom), $urandom);
  endtask

  initial begin
    int  pick;
    bit  first;
    bit  hold_done;
    bit  pause_done;
    sb = new();
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = KW'($urandom);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: empty-table cases, extremes, duplicate, absent keys
    send_request(FUNC_LOOKUP, 16'h0001, 32'h0);
    send_request(FUNC_DELETE, 16'h0001, 32'h0);
    send_request(FUNC_CHANGE, 16'h0001, 32'hFFFF_FFFF);
    send_request(FUNC_ADD,    16'h0000, 32'h0000_0000);
    send_request(FUNC_ADD,    16'hFFFF, 32'hFFFF_FFFF);
    send_request(FUNC_ADD,    16'h0000, 32'h1111_1111);
    send_request(FUNC_LOOKUP, 16'h0000, 32'h0);
    send_request(FUNC_LOOKUP, 16'hFFFF, 32'h0);
    send_request(FUNC_CHANGE, 16'hFFFF, 32'h5A5A_A5A5);
    send_request(FUNC_LOOKUP, 16'hFFFF, 32'h0);
    send_request(FUNC_LOOKUP, 16'h1234, 32'h0);
    send_request(FUNC_DELETE, 16'h1234, 32'h0);
    send_request(FUNC_CHANGE, 16'h1234, 32'hFFFF_FFFF);
    send_request(FUNC_DELETE, 16'h0000, 32'h0);
    send_request(FUNC_LOOKUP, 16'h0000, 32'h0);
    send_request(FUNC_DELETE, 16'hFFFF, 32'h0);
    send_request(FUNC_LOOKUP, 16'hFFFF, 32'h0);

    first      = 1'b1;
    hold_done  = 1'b0;
    pause_done = 1'b0;
    while (sent_count < ITEM_TARGET) begin
      quiet = (sent_count >= ITEM_TARGET - QUIET_ITEMS);
      send_idle_pct = quiet ? 0 : pick_pct();
      recv_idle_pct = quiet ? 0 : pick_pct();
      if (!hold_done && sent_count >= 500) begin
        long_hold_req = 1'b1;
        hold_done     = 1'b1;
      end
      if (!pause_done && sent_count >= 900) begin
        wait_all_replies();
        pause_done = 1'b1;
      end
      // start with a fill so the full-table case shows up early
      pick  = first ? 0 : $urandom_range(99);
      first = 1'b0;
      if (pick < 20) run_fill();
      else if (pick < 40) run_drain();
      else if (pick < 85) run_mixed();
      else run_noise();
    end

    @(negedge clk);
    in_valid = 1'b0;
    wait_all_replies();
    repeat (40) @(posedge clk);

    $display("Checked %0d replies: ok %0d, duplicate %0d, empty %0d, not found %0d, full %0d",
             sb.checked_count, sb.status_seen[ST_OK], sb.status_seen[ST_DUP],
             sb.status_seen[ST_EMPTY], sb.status_seen[ST_NOTFOUND], sb.status_seen[ST_FULL]);
    $display("Table filled to capacity %0d times and drained to empty %0d times",
             full_fills, drains);
    if (sb.error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
